### design/mbe_pkg.sv
package mbe_pkg;

  localparam int SHADE_W = 8;
  localparam logic [SHADE_W-1:0] SHADE_MAX = 8'hFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } mbe_state_t;

endpackage

### design/mbe_if.sv
interface mbe_point_if #(parameter int COORD_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_real;
  logic signed [COORD_WIDTH-1:0] point_imag;

  modport source (output valid, point_real, point_imag, input ready);
  modport sink   (input valid, point_real, point_imag, output ready);
endinterface

interface mbe_job_if #(parameter int COORD_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_real;
  logic signed [COORD_WIDTH-1:0] point_imag;
  logic                          escaped;

  modport source (output valid, point_real, point_imag, escaped, input ready);
  modport sink   (input valid, point_real, point_imag, escaped, output ready);
endinterface

interface mbe_shade_if ();
  logic                         valid;
  logic                         ready;
  logic [mbe_pkg::SHADE_W-1:0]  shade;

  modport source (output valid, shade, input ready);
  modport sink   (input valid, shade, output ready);
endinterface

### design/mbe_front.sv
module mbe_front #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 28
) (
  input  logic    clk,
  input  logic    rst_n,
  mbe_point_if.sink in_point,
  mbe_job_if.source job
);
  import mbe_pkg::*;

  localparam int EW = ((COORD_WIDTH > FRACTION_BITS + 3) ? COORD_WIDTH : FRACTION_BITS + 3) + 1;
  localparam logic signed [EW-1:0] BOUND  = EW'(1) <<< (FRACTION_BITS + 1);
  localparam logic signed [EW-1:0] NBOUND = -BOUND;

  logic signed [COORD_WIDTH-1:0] qr_r [QUEUE_DEPTH];
  logic signed [COORD_WIDTH-1:0] qi_r [QUEUE_DEPTH];
  logic                          qe_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]             wr_ptr_r;
  logic [QPTR_W-1:0]             rd_ptr_r;
  logic [QCNT_W-1:0]             count_r;

  logic signed [EW-1:0] cr_x;
  logic signed [EW-1:0] ci_x;
  logic                 outside;
  logic                 push;
  logic                 pop;

  // classify: a point outside the box leaves on the first iteration
  assign cr_x    = EW'(in_point.point_real);
  assign ci_x    = EW'(in_point.point_imag);
  assign outside = (cr_x > BOUND) || (cr_x < NBOUND) || (ci_x > BOUND) || (ci_x < NBOUND);

  assign in_point.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push           = in_point.valid && in_point.ready;
  assign pop            = job.valid && job.ready;

  assign job.valid      = (count_r != '0);
  assign job.point_real = qr_r[rd_ptr_r];
  assign job.point_imag = qi_r[rd_ptr_r];
  assign job.escaped    = qe_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      qr_r[wr_ptr_r] <= in_point.point_real;
      qi_r[wr_ptr_r] <= in_point.point_imag;
      qe_r[wr_ptr_r] <= outside;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      priority if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end else begin
        count_r <= count_r;
      end
    end
  end

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= QCNT_W'(QUEUE_DEPTH)) && !(push && count_r == QCNT_W'(QUEUE_DEPTH)))
    else $error("queue overfilled");
`endif

endmodule

### design/mbe_back.sv
module mbe_back #(
  parameter int COORD_WIDTH     = 32,
  parameter int FRACTION_BITS   = 28,
  parameter int ITERATION_LIMIT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  mbe_job_if.sink    job,
  mbe_shade_if.source out_shade
);
  import mbe_pkg::*;

  localparam int ZW   = FRACTION_BITS + 3;
  localparam int SQW  = FRACTION_BITS + 4;
  localparam int XW   = FRACTION_BITS + 5;
  localparam int CXW  = (COORD_WIDTH > ZW) ? COORD_WIDTH : ZW;
  localparam int SW   = ((COORD_WIDTH > XW) ? COORD_WIDTH : XW) + 2;
  localparam int IW   = $clog2(ITERATION_LIMIT + 1);
  localparam int LAST = ITERATION_LIMIT - 1;
  localparam logic signed [SW-1:0] BOUND  = SW'(1) <<< (FRACTION_BITS + 1);
  localparam logic signed [SW-1:0] NBOUND = -BOUND;

  mbe_state_t state_r;
  mbe_state_t state_nxt;

  logic signed [COORD_WIDTH-1:0] cr_r;
  logic signed [COORD_WIDTH-1:0] ci_r;
  logic signed [ZW-1:0]          zr_r;
  logic signed [ZW-1:0]          zi_r;
  logic [IW-1:0]                 iter_r;
  logic signed [SQW-1:0]         sqr_r;
  logic signed [SQW-1:0]         sqi_r;
  logic signed [XW-1:0]          crs_r;
  logic [SHADE_W-1:0]            res_r;
  logic [SHADE_W-1:0]            shade_r;
  logic                          out_valid_r;

  logic signed [CXW-1:0]  cr_x;
  logic signed [CXW-1:0]  ci_x;
  logic signed [2*ZW-1:0] prod_rr;
  logic signed [2*ZW-1:0] prod_ii;
  logic signed [2*ZW-1:0] prod_ri;
  logic signed [SW-1:0]   sum_r;
  logic signed [SW-1:0]   sum_i;
  logic                   sum_esc;
  logic                   last_iter;
  logic                   out_load;

  assign cr_x = CXW'(job.point_real);
  assign ci_x = CXW'(job.point_imag);

  assign prod_rr = zr_r * zr_r;
  assign prod_ii = zi_r * zi_r;
  assign prod_ri = zr_r * zi_r;

  assign sum_r   = SW'(sqr_r) - SW'(sqi_r) + SW'(cr_r);
  assign sum_i   = SW'(crs_r) + SW'(ci_r);
  assign sum_esc = (sum_r > BOUND) || (sum_r < NBOUND) || (sum_i > BOUND) || (sum_i < NBOUND);
  assign last_iter = (iter_r == IW'(LAST));

  always_comb begin
    state_nxt = state_r;
    job.ready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        job.ready = 1'b1;
        if (job.valid) begin
          state_nxt = (job.escaped || ITERATION_LIMIT == 1) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        state_nxt = (sum_esc || last_iter) ? ST_FIN : ST_MUL;
      end
      ST_FIN: begin
        if (!out_valid_r || out_shade.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // iteration zero is settled by the front: z becomes c when c stays in the box
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (job.valid) begin
          cr_r   <= job.point_real;
          ci_r   <= job.point_imag;
          zr_r   <= cr_x[ZW-1:0];
          zi_r   <= ci_x[ZW-1:0];
          iter_r <= IW'(1);
          res_r  <= job.escaped ? SHADE_MAX : '0;
        end
      end
      ST_MUL: begin
        sqr_r <= prod_rr[FRACTION_BITS +: SQW];
        sqi_r <= prod_ii[FRACTION_BITS +: SQW];
        crs_r <= prod_ri[FRACTION_BITS-1 +: XW];
      end
      ST_ADD: begin
        if (sum_esc) begin
          res_r <= SHADE_MAX - SHADE_W'(iter_r);
        end else begin
          zr_r   <= sum_r[ZW-1:0];
          zi_r   <= sum_i[ZW-1:0];
          iter_r <= iter_r + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      shade_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_shade.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_shade.valid = out_valid_r;
  assign out_shade.shade = shade_r;

`ifndef SYNTH
  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_ADD) |-> (iter_r != '0 && iter_r <= IW'(LAST)))
    else $error("iteration count out of range");
  a_job_start: assert property (@(posedge clk) disable iff (!rst_n)
    (job.valid && job.ready) |=> (state_r == ST_MUL || state_r == ST_FIN))
    else $error("job taken without starting work");
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && shade_r == $past(res_r) && state_r == ST_IDLE))
    else $error("result not presented after finish");
`endif

endmodule

### design/mandelbrot_escape_time_pixel.sv
// Channel     Role    Payload
// in_point    sink    point_real, point_imag (signed fixed point)
// out_shade   source  shade (8 bit grey)
//
// A point outside the box on entry goes from idle straight to the finish state.
// Otherwise each further iteration passes the multiply then add/compare
// states, until the point escapes or the iteration limit is reached.
// The two-entry input queue accepts points while the iterator is busy.
// Reset is synchronous and clears the queue, the iterator state and the output valid.
// A stalled result holds in its output register; the next result then waits in the finish state.
module mandelbrot_escape_time_pixel #(
  parameter int ITERATION_LIMIT = 256,
  parameter int COORD_WIDTH     = 32,
  parameter int FRACTION_BITS   = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  mbe_point_if.sink   in_point,
  mbe_shade_if.source out_shade
);
  import mbe_pkg::*;

  mbe_job_if #(.COORD_WIDTH(COORD_WIDTH)) job ();

  mbe_front #(
    .COORD_WIDTH  (COORD_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_point(in_point),
    .job     (job)
  );

  mbe_back #(
    .COORD_WIDTH    (COORD_WIDTH),
    .FRACTION_BITS  (FRACTION_BITS),
    .ITERATION_LIMIT(ITERATION_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job),
    .out_shade(out_shade)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int ITER_LIMIT  = 256;
  localparam int COORD_W     = 32;
  localparam int FRAC_BITS   = 28;
  localparam int SHADE_W     = mbe_pkg::SHADE_W;
  localparam int RANDOM_PTS  = 1300;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_WAIT  = 2 * ITER_LIMIT + 40;
  localparam longint CYCLE_LIMIT = 5_000_000;

  localparam int Q_QUARTER = 32'h0400_0000;
  localparam int Q_ONE     = 32'h1000_0000;
  localparam int Q_TWO     = 32'h2000_0000;
  localparam int BOX_SPAN  = 32'h2400_0000;

  localparam logic signed [COORD_W-1:0] EDGE_VALUES [0:8] = '{
    32'sh2000_0000, 32'shE000_0000, 32'sh1FFF_FFFF, 32'sh2000_0001, 32'shDFFF_FFFF,
    32'shE000_0001, 32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000
  };

  typedef enum int {RX_EAGER, RX_SPARSE, RX_BUSY, RX_PULSE} rx_mode_t;

  typedef struct {
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
    bit                        typed;
    logic [SHADE_W-1:0]        shade;
  } shade_row_t;

  logic clk;
  logic rst_n;

  mbe_point_if #(.COORD_WIDTH(COORD_W)) in_if ();
  mbe_shade_if                          out_if ();

  mandelbrot_escape_time_pixel #(
    .ITERATION_LIMIT(ITER_LIMIT),
    .COORD_WIDTH    (COORD_W),
    .FRACTION_BITS  (FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_point (in_if),
    .out_shade(out_if)
  );

  shade_row_t pending_shades[$];
  int         fail_count;
  int         points_sent;
  int         shades_checked;
  int         outside_count;
  int         never_count;
  int         deep_count;
  int         hold_requests;
  int         burst_left;
  longint     cycle_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned escape_iteration(logic signed [COORD_W-1:0] c_re,
                                                   logic signed [COORD_W-1:0] c_im);
    longint cr, ci, zr, zi, xr, xi, sr, si, bnd;
    int unsigned iter;
    cr  = c_re;
    ci  = c_im;
    bnd = longint'(2) <<< FRAC_BITS;
    zr  = 0;
    zi  = 0;
    for (iter = 0; iter < ITER_LIMIT; iter++) begin
      xr = ((zr * zr) >>> FRAC_BITS) - ((zi * zi) >>> FRAC_BITS);
      xi = (zr * zi) >>> (FRAC_BITS - 1);
      sr = xr + cr;
      si = xi + ci;
      if (sr > bnd || sr < -bnd || si > bnd || si < -bnd) return iter;
      zr = sr;
      zi = si;
    end
    return ITER_LIMIT;
  endfunction

  function automatic logic [SHADE_W-1:0] shade_for(int unsigned iter);
    if (iter >= ITER_LIMIT) return '0;
    return mbe_pkg::SHADE_MAX - SHADE_W'(iter);
  endfunction

  // smallest step right of the cusp at 0.25 that escapes by the given iteration
  function automatic logic signed [COORD_W-1:0] cusp_point_escaping_by(int unsigned target);
    int lo, hi, mid;
    lo = 0;
    hi = 1 << 20;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (escape_iteration(Q_QUARTER + mid, '0) <= target) hi = mid;
      else lo = mid;
    end
    return Q_QUARTER + hi;
  endfunction

  function automatic void pick_point(output logic signed [COORD_W-1:0] re,
                                     output logic signed [COORD_W-1:0] im);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      re = $urandom;
      im = $urandom;
    end else if (roll < 55) begin
      re = int'($urandom_range(0, 2 * BOX_SPAN)) - BOX_SPAN;
      im = int'($urandom_range(0, 2 * BOX_SPAN)) - BOX_SPAN;
    end else if (roll < 80) begin
      if ($urandom_range(0, 1) == 0) begin
        re = Q_QUARTER + int'($urandom_range(0, 1 << 22));
        im = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      end else begin
        re = -3 * Q_QUARTER + int'($urandom_range(0, 1 << 16)) - (1 << 15);
        im = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      end
    end else if (roll < 90) begin
      re = int'($urandom_range(0, Q_QUARTER)) - Q_QUARTER / 2;
      im = int'($urandom_range(0, Q_QUARTER)) - Q_QUARTER / 2;
    end else begin
      re = EDGE_VALUES[$urandom_range(0, 8)];
      im = EDGE_VALUES[$urandom_range(0, 8)];
    end
  endfunction

  function automatic void log_mismatch(string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endfunction

  task automatic send_point(input shade_row_t row);
    shade_row_t  want;
    int unsigned gap;
    want = row;
    if (!row.typed) want.shade = shade_for(escape_iteration(row.re, row.im));
    in_if.valid      <= 1'b1;
    in_if.point_real <= row.re;
    in_if.point_imag <= row.im;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_shades.push_back(want);
    points_sent++;
    if (want.shade == mbe_pkg::SHADE_MAX) outside_count++;
    else if (want.shade == '0) never_count++;
    else if (want.shade < 8'd128) deep_count++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic drain_shades();
    in_if.valid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    shade_row_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_shades.size() == 0) begin
        log_mismatch($sformatf("unexpected shade %0d with nothing outstanding", out_if.shade));
      end else begin
        want = pending_shades.pop_front();
        if (out_if.shade !== want.shade)
          log_mismatch($sformatf("shade mismatch for c=(%h,%h): expected %0d, got %0d",
                                 want.re, want.im, want.shade, out_if.shade));
      end
      shades_checked++;
    end
  end

  initial begin : rx_stall
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       holds_seen;
    int       pulse;
    mode       = RX_EAGER;
    mode_left  = 0;
    hold_left  = 0;
    holds_seen = 0;
    pulse      = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 400);
      end
      mode_left--;
      pulse++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_EAGER:  out_if.ready <= 1'b1;
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_BUSY:   out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= pulse[2];
        endcase
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[mandelbrot_escape_time_pixel] ERROR");
    $finish;
  end

  initial begin : stimulus
    shade_row_t                directed_rows[$];
    shade_row_t                row;
    logic signed [COORD_W-1:0] re, im;
    int                        idx;
    fail_count     = 0;
    points_sent    = 0;
    shades_checked = 0;
    outside_count  = 0;
    never_count    = 0;
    deep_count     = 0;
    hold_requests  = 0;
    burst_left     = 0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.point_real = '0;
    in_if.point_imag = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_rows = '{
      '{32'sh0000_0000, 32'sh0000_0000, 1'b1, 8'd0},
      '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 8'd255},
      '{32'sh8000_0000, 32'sh8000_0000, 1'b1, 8'd255},
      '{32'sh7FFF_FFFF, 32'sh0000_0000, 1'b1, 8'd255},
      '{32'sh0000_0000, 32'sh8000_0000, 1'b1, 8'd255},
      '{32'sh2000_0000, 32'sh0000_0000, 1'b1, 8'd254},
      '{32'shE000_0000, 32'sh0000_0000, 1'b1, 8'd0},
      '{32'sh0000_0000, 32'sh2000_0000, 1'b1, 8'd254},
      '{32'sh0000_0000, 32'shE000_0000, 1'b1, 8'd254},
      '{32'sh2000_0001, 32'sh0000_0000, 1'b1, 8'd255},
      '{32'shDFFF_FFFF, 32'sh0000_0000, 1'b1, 8'd255},
      '{32'sh0000_0000, 32'sh2000_0001, 1'b1, 8'd255},
      '{32'shE000_0000, 32'sh2000_0000, 1'b1, 8'd254},
      '{32'shF000_0000, 32'sh0000_0000, 1'b1, 8'd0},
      '{32'sh0000_0000, 32'sh1000_0000, 1'b1, 8'd0},
      '{32'sh1000_0000, 32'sh0000_0000, 1'b1, 8'd253},
      '{32'sh5A5A_5A5A, 32'shA5A5_A5A5, 1'b1, 8'd255},
      '{32'sh0400_0000, 32'sh0000_0000, 1'b0, 8'd0},
      '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b0, 8'd0},
      '{32'sh0000_0001, 32'sh0000_0001, 1'b0, 8'd0},
      '{32'shE800_0000, 32'sh0000_0000, 1'b0, 8'd0},
      '{32'shF400_0000, 32'sh0010_0000, 1'b0, 8'd0}
    };
    // escape on the last and the second to last iteration
    directed_rows.push_back('{cusp_point_escaping_by(ITER_LIMIT - 1), '0, 1'b0, 8'd0});
    directed_rows.push_back('{cusp_point_escaping_by(ITER_LIMIT - 2), '0, 1'b0, 8'd0});

    foreach (directed_rows[i]) send_point(directed_rows[i]);
    drain_shades();

    for (idx = 0; idx < RANDOM_PTS; idx++) begin
      if (idx == RANDOM_PTS / 3) hold_requests++;
      if (idx == (2 * RANDOM_PTS) / 3) drain_shades();
      pick_point(re, im);
      row = '{re, im, 1'b0, 8'd0};
      send_point(row);
    end

    drain_shades();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d points sent, %0d shades checked, %0d mismatches", points_sent,
             shades_checked, fail_count);
    $display("%0d escaped on entry, %0d reached the iteration limit, %0d escaped late",
             outside_count, never_count, deep_count);
    if (fail_count == 0 && pending_shades.size() == 0) begin
      $display("[mandelbrot_escape_time_pixel] OK");
    end else begin
      $display("[mandelbrot_escape_time_pixel] ERROR");
    end
    $finish;
  end

endmodule

### mandelbrot_escape_time_pixel.f
design/mbe_pkg.sv
design/mbe_if.sv
design/mbe_front.sv
design/mbe_back.sv
design/mandelbrot_escape_time_pixel.sv
tb/sv/tb.sv
